[hdl/prime_sieve_query_engine_defines.svh]
// ----------------------------------------------------------------------------
// prime_sieve_query_engine_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_QUERY_ENGINE_DEFINES_SVH
`define PRIME_SIEVE_QUERY_ENGINE_DEFINES_SVH

// same-cycle implication
`define PSE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Sizes, codes and types of the prime sieve query engine.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int MAX_LIMIT   = 65536;
    localparam int PRIME_SLOTS = 8192;

    localparam int BM_DEPTH  = MAX_LIMIT / 2;
    localparam int BM_AW     = $clog2(BM_DEPTH);
    localparam int TOP_INDEX = (MAX_LIMIT - 3) / 2;
    localparam int LIM_W     = $clog2(MAX_LIMIT) + 1;
    localparam int NUM_W     = LIM_W + 1;
    localparam int P_W       = $clog2(MAX_LIMIT);
    localparam int PL_AW     = $clog2(PRIME_SLOTS);
    localparam int CNT_W     = PL_AW + 1;

    localparam int IDX_W  = 13;
    localparam int VAL_W  = 32;
    localparam int PV_W   = 16;
    localparam int ST_W   = 2;
    localparam int CFG_W  = 17;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int RESET_LIMIT = 1024;

    localparam logic [PADDR_W-3:0] REG_INITIAL_LIMIT = '0;

    localparam logic [1:0] OP_NTH      = 2'd0;
    localparam logic [1:0] OP_TEST_LOW = 2'd1;
    localparam logic [1:0] OP_TEST     = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_BIG   = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] prime_index;
        logic [VAL_W-1:0] test_value;
    } item_t;

    typedef struct packed {
        logic [PV_W-1:0] prime_value;
        logic            prime_flag;
        logic [ST_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic             load;
        logic [CFG_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [P_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] rem;
    } div_rsp_t;

endpackage

[hdl/pse_if.sv]
// ----------------------------------------------------------------------------
// pse_if
// Query and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface pse_item_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [pse_pkg::IDX_W-1:0]  prime_index;
    logic [pse_pkg::VAL_W-1:0]  test_value;

    modport source (output valid, kind, prime_index, test_value, input ready);
    modport sink   (input valid, kind, prime_index, test_value, output ready);
endinterface

interface pse_result_if;
    logic                       valid;
    logic                       ready;
    logic [pse_pkg::PV_W-1:0]   prime_value;
    logic                       prime_flag;
    logic [pse_pkg::ST_W-1:0]   status;

    modport source (output valid, prime_value, prime_flag, status, input ready);
    modport sink   (input valid, prime_value, prime_flag, status, output ready);
endinterface

[hdl/pse_front.sv]
// ----------------------------------------------------------------------------
// pse_front
// Accepts queries, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pse_front (
    input  logic           clk,
    input  logic           rst_n,
    pse_item_if.sink       req,
    output logic           item_valid,
    output pse_pkg::item_t item,
    input  logic           item_pop
);
    import pse_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    assign req.ready  = (cnt_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.prime_index = req.prime_index;
        in_item.test_value  = req.test_value;
        if (!req.kind)
            in_item.op = OP_NTH;
        else if (req.test_value < VAL_W'(2))
            in_item.op = OP_TEST_LOW;
        else
            in_item.op = OP_TEST;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

[hdl/pse_divider.sv]
// ----------------------------------------------------------------------------
// pse_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pse_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pse_pkg::div_req_t req,
    output pse_pkg::div_rsp_t rsp
);
    import pse_pkg::*;

    localparam int CW = $clog2(VAL_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [P_W-1:0]   rem_reg, rem_next;
    logic [VAL_W-1:0] dvd_reg, dvd_next;
    logic [P_W-1:0]   dvs_reg, dvs_next;
    logic [P_W:0]     trial;

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[VAL_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = P_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[P_W-1:0];
            dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(VAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

endmodule

[hdl/pse_engine.sv]
// ----------------------------------------------------------------------------
// pse_engine
// Sieve sequencer, bitmap and prime list memories, query execution and
// result register.
// ----------------------------------------------------------------------------
module pse_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  pse_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  pse_pkg::item_t   item,
    output logic             item_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output pse_pkg::result_t out_data
);
    import pse_pkg::*;

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_SEG_START = 5'd1;
    localparam logic [4:0] S_K_CHECK   = 5'd2;
    localparam logic [4:0] S_K_WAIT    = 5'd3;
    localparam logic [4:0] S_K_SQ      = 5'd4;
    localparam logic [4:0] S_K_CMP     = 5'd5;
    localparam logic [4:0] S_K_DIV     = 5'd6;
    localparam logic [4:0] S_MARK      = 5'd7;
    localparam logic [4:0] S_SCAN_RD   = 5'd8;
    localparam logic [4:0] S_SCAN_CHK  = 5'd9;
    localparam logic [4:0] S_SCAN_SQ   = 5'd10;
    localparam logic [4:0] S_SCAN_CMP  = 5'd11;
    localparam logic [4:0] S_SCAN_NEXT = 5'd12;
    localparam logic [4:0] S_LSQ       = 5'd13;
    localparam logic [4:0] S_IDLE      = 5'd14;
    localparam logic [4:0] S_DISPATCH  = 5'd15;
    localparam logic [4:0] S_EXT_CHECK = 5'd16;
    localparam logic [4:0] S_NTH_RD    = 5'd17;
    localparam logic [4:0] S_BM_RD     = 5'd18;
    localparam logic [4:0] S_BM_CHK    = 5'd19;
    localparam logic [4:0] S_TD_RD     = 5'd20;
    localparam logic [4:0] S_TD_WAIT   = 5'd21;
    localparam logic [4:0] S_TD_DIV    = 5'd22;
    localparam logic [4:0] S_RESULT    = 5'd23;

    logic [4:0]       state_reg, state_next;
    logic [BM_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [LIM_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base_count_reg, base_count_next;
    logic [BM_AW-1:0] sieved_reg, sieved_next;
    logic [LIM_W-1:0] cur_lim_reg, cur_lim_next;
    logic [P_W-1:0]   largest_reg, largest_next;
    logic [2*P_W-1:0] lsq_reg, lsq_next;
    logic [BM_AW-1:0] lo_reg, lo_next;
    logic [BM_AW-1:0] hi_reg, hi_next;
    logic [LIM_W-1:0] hi_num_reg, hi_num_next;
    logic [CNT_W-1:0] known_reg, known_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [2*P_W-1:0] sq_reg, sq_next;
    logic [NUM_W-1:0] m_reg, m_next;
    logic [NUM_W-1:0] step_reg, step_next;
    logic [BM_AW-1:0] idx_reg, idx_next;
    logic             init_mode_reg, init_mode_next;
    logic             mark_scan_reg, mark_scan_next;
    item_t            cur_reg, cur_next;
    result_t          res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             bm_mem [BM_DEPTH];
    logic             bm_we, bm_wdata, bm_q_reg;
    logic [BM_AW-1:0] bm_waddr, bm_raddr;
    logic [P_W-1:0]   pl_mem [PRIME_SLOTS];
    logic             pl_we;
    logic [PL_AW-1:0] pl_waddr, pl_raddr;
    logic [P_W-1:0]   pl_wdata, pl_q_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [LIM_W-1:0] lo_num;
    logic [LIM_W-1:0] lim_m3;
    logic [NUM_W-1:0] st_add, st1, st2, st3;
    logic [NUM_W-1:0] m_m3;
    logic [P_W-1:0]   scan_p;
    logic [LIM_W-1:0] seg_size, seg_sum;
    logic [VAL_W-1:0] n_m3;

    pse_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_waddr] <= bm_wdata;
        bm_q_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
            pl_mem[pl_waddr] <= pl_wdata;
        pl_q_reg <= pl_mem[pl_raddr];
    end

    always_comb
    begin
        lo_num   = LIM_W'({lo_reg, 1'b1}) + LIM_W'(2);
        lim_m3   = lim_reg - LIM_W'(3);
        st_add   = (div_rsp.rem == '0) ? '0 : NUM_W'(p_reg) - NUM_W'(div_rsp.rem);
        st1      = NUM_W'(lo_num) + st_add;
        st2      = st1[0] ? st1 : st1 + NUM_W'(p_reg);
        st3      = (st2 < sq_reg[NUM_W-1:0]) ? sq_reg[NUM_W-1:0] : st2;
        m_m3     = m_reg - NUM_W'(3);
        scan_p   = P_W'({idx_reg, 1'b1}) + P_W'(2);
        seg_size = (cur_lim_reg[LIM_W-1:1] == '0) ? LIM_W'(1) : LIM_W'(cur_lim_reg[LIM_W-1:1]);
        seg_sum  = LIM_W'(sieved_reg) + seg_size;
        n_m3     = cur_reg.test_value - VAL_W'(3);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        lim_next        = lim_reg;
        count_next      = count_reg;
        base_count_next = base_count_reg;
        sieved_next     = sieved_reg;
        cur_lim_next    = cur_lim_reg;
        largest_next    = largest_reg;
        lsq_next        = lsq_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hi_num_next     = hi_num_reg;
        known_next      = known_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        sq_next         = sq_reg;
        m_next          = m_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        init_mode_next  = init_mode_reg;
        mark_scan_next  = mark_scan_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        item_pop        = 1'b0;
        bm_we           = 1'b0;
        bm_waddr        = clr_idx_reg;
        bm_wdata        = 1'b0;
        bm_raddr        = idx_reg;
        pl_we           = 1'b0;
        pl_waddr        = count_reg[PL_AW-1:0];
        pl_wdata        = scan_p;
        pl_raddr        = k_reg[PL_AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = VAL_W'(lo_num);
        div_req.divisor  = p_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we        = 1'b1;
                clr_idx_next = clr_idx_reg + BM_AW'(1);
                if (clr_idx_reg == BM_AW'(BM_DEPTH - 1))
                begin
                    pl_we          = 1'b1;
                    pl_waddr       = '0;
                    pl_wdata       = P_W'(2);
                    count_next     = CNT_W'(1);
                    largest_next   = P_W'(2);
                    cur_lim_next   = lim_reg;
                    sieved_next    = lim_m3[BM_AW:1];
                    lo_next        = '0;
                    hi_next        = lim_m3[BM_AW:1];
                    init_mode_next = 1'b1;
                    state_next     = S_SEG_START;
                end
            end
            S_SEG_START:
            begin
                hi_num_next = LIM_W'({hi_reg, 1'b1}) + LIM_W'(2);
                known_next  = count_reg;
                k_next      = CNT_W'(1);
                state_next  = S_K_CHECK;
            end
            S_K_CHECK:
            begin
                if (k_reg >= known_reg)
                begin
                    idx_next   = lo_reg;
                    state_next = S_SCAN_RD;
                end
                else
                    state_next = S_K_WAIT;
            end
            S_K_WAIT:
            begin
                p_next     = pl_q_reg;
                state_next = S_K_SQ;
            end
            S_K_SQ:
            begin
                sq_next    = p_reg * p_reg;
                state_next = S_K_CMP;
            end
            S_K_CMP:
            begin
                if (sq_reg > (2*P_W)'(hi_num_reg))
                begin
                    idx_next   = lo_reg;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_K_DIV;
                end
            end
            S_K_DIV:
            begin
                if (div_rsp.done)
                begin
                    m_next         = st3;
                    step_next      = NUM_W'({p_reg, 1'b0});
                    mark_scan_next = 1'b0;
                    state_next     = S_MARK;
                end
            end
            S_MARK:
            begin
                if (m_reg > NUM_W'(hi_num_reg))
                begin
                    if (mark_scan_reg)
                        state_next = S_SCAN_NEXT;
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_K_CHECK;
                    end
                end
                else
                begin
                    bm_we    = 1'b1;
                    bm_waddr = m_m3[BM_AW:1];
                    bm_wdata = 1'b1;
                    m_next   = m_reg + step_reg;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (bm_q_reg)
                    state_next = S_SCAN_NEXT;
                else
                begin
                    p_next = scan_p;
                    if (count_reg < CNT_W'(PRIME_SLOTS))
                    begin
                        pl_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (init_mode_reg)
                            largest_next = scan_p;
                    end
                    state_next = S_SCAN_SQ;
                end
            end
            S_SCAN_SQ:
            begin
                sq_next    = p_reg * p_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sq_reg <= (2*P_W)'(hi_num_reg))
                begin
                    m_next         = sq_reg[NUM_W-1:0];
                    step_next      = NUM_W'({p_reg, 1'b0});
                    mark_scan_next = 1'b1;
                    state_next     = S_MARK;
                end
                else
                    state_next = S_SCAN_NEXT;
            end
            S_SCAN_NEXT:
            begin
                if (idx_reg == hi_reg)
                begin
                    if (init_mode_reg)
                    begin
                        base_count_next = count_reg;
                        init_mode_next  = 1'b0;
                        state_next      = S_LSQ;
                    end
                    else
                    begin
                        sieved_next = hi_reg;
                        if (cur_lim_reg > LIM_W'(MAX_LIMIT / 2))
                            cur_lim_next = LIM_W'(MAX_LIMIT);
                        else
                            cur_lim_next = {cur_lim_reg[LIM_W-2:0], 1'b0};
                        state_next = S_EXT_CHECK;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + BM_AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_LSQ:
            begin
                lsq_next   = largest_reg * largest_reg;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    cur_next   = item;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next.prime_value = '0;
                res_next.prime_flag  = 1'b0;
                res_next.status      = ST_OK;
                unique case (cur_reg.op)
                    OP_NTH:
                        state_next = S_EXT_CHECK;
                    OP_TEST_LOW:
                        state_next = S_RESULT;
                    OP_TEST:
                    begin
                        if (cur_reg.test_value > lsq_reg)
                        begin
                            res_next.status = ST_BIG;
                            state_next      = S_RESULT;
                        end
                        else if (cur_reg.test_value <= VAL_W'(largest_reg))
                        begin
                            if (cur_reg.test_value == VAL_W'(2))
                            begin
                                res_next.prime_flag = 1'b1;
                                state_next          = S_RESULT;
                            end
                            else if (cur_reg.test_value[0])
                                state_next = S_BM_RD;
                            else
                                state_next = S_RESULT;
                        end
                        else
                        begin
                            res_next.prime_flag = 1'b1;
                            k_next              = '0;
                            state_next          = S_TD_RD;
                        end
                    end
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_EXT_CHECK:
            begin
                if (CNT_W'(cur_reg.prime_index) >= count_reg &&
                    count_reg < CNT_W'(PRIME_SLOTS) &&
                    sieved_reg < BM_AW'(TOP_INDEX))
                begin
                    lo_next = sieved_reg + BM_AW'(1);
                    if (seg_sum > LIM_W'(TOP_INDEX))
                        hi_next = BM_AW'(TOP_INDEX);
                    else
                        hi_next = seg_sum[BM_AW-1:0];
                    state_next = S_SEG_START;
                end
                else if (CNT_W'(cur_reg.prime_index) < count_reg)
                begin
                    pl_raddr   = cur_reg.prime_index[PL_AW-1:0];
                    state_next = S_NTH_RD;
                end
                else
                begin
                    res_next.status = ST_RANGE;
                    state_next      = S_RESULT;
                end
            end
            S_NTH_RD:
            begin
                res_next.prime_value = PV_W'(pl_q_reg);
                state_next           = S_RESULT;
            end
            S_BM_RD:
            begin
                bm_raddr   = n_m3[BM_AW:1];
                state_next = S_BM_CHK;
            end
            S_BM_CHK:
            begin
                res_next.prime_flag = !bm_q_reg;
                state_next          = S_RESULT;
            end
            S_TD_RD:
            begin
                if (k_reg >= base_count_reg)
                    state_next = S_RESULT;
                else
                    state_next = S_TD_WAIT;
            end
            S_TD_WAIT:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cur_reg.test_value;
                div_req.divisor  = pl_q_reg;
                state_next       = S_TD_DIV;
            end
            S_TD_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem == '0)
                    begin
                        res_next.prime_flag = 1'b0;
                        state_next          = S_RESULT;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_TD_RD;
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase

        if (cfg.load)
        begin
            if (cfg.value < CFG_W'(3))
                lim_next = LIM_W'(3);
            else if (cfg.value > CFG_W'(MAX_LIMIT))
                lim_next = LIM_W'(MAX_LIMIT);
            else
                lim_next = LIM_W'(cfg.value);
            clr_idx_next = '0;
            state_next   = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            lim_reg       <= LIM_W'(RESET_LIMIT);
            count_reg     <= '0;
            init_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            lim_reg       <= lim_next;
            count_reg     <= count_next;
            init_mode_reg <= init_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_count_reg <= base_count_next;
        sieved_reg     <= sieved_next;
        cur_lim_reg    <= cur_lim_next;
        largest_reg    <= largest_next;
        lsq_reg        <= lsq_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hi_num_reg     <= hi_num_next;
        known_reg      <= known_next;
        k_reg          <= k_next;
        p_reg          <= p_next;
        sq_reg         <= sq_next;
        m_reg          <= m_next;
        step_reg       <= step_next;
        idx_reg        <= idx_next;
        mark_scan_reg  <= mark_scan_next;
        cur_reg        <= cur_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

[hdl/prime_sieve_query_engine.sv]
// ----------------------------------------------------------------------------
// prime_sieve_query_engine
// Segmented odd-only sieve with nth-prime and primality queries.
// ----------------------------------------------------------------------------
// After reset and after every write of initial_limit the block clears its
// 32768-entry composite bitmap (no queries taken) and then sieves up to the
// limit; queries wait in a two-entry queue meanwhile. A query is taken from
// the queue only when the previous one is done. A covered nth-prime index
// is one prime list read and a test up to the largest first-pass prime is
// one bitmap lookup; for an uncovered index, each extension segment strikes
// the multiples of each base prime, one multiple struck per cycle, then
// scans each odd number and strikes from the square of each new prime;
// a trial division divides by each first-pass prime in turn in the
// one-bit-per-cycle remainder unit. Results sit in an output register so the
// next query can start while one waits to be taken.
module prime_sieve_query_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    pse_item_if.sink                      req,
    pse_result_if.source                  rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pse_pkg::PADDR_W-1:0]   paddr,
    input  logic [pse_pkg::DATA_W-1:0]    pwdata,
    output logic [pse_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import pse_pkg::*;

    logic [CFG_W-1:0] initial_limit_reg, initial_limit_next;
    logic             reg_hit;
    cfg_t             cfg;
    logic             item_valid;
    item_t            item;
    logic             item_pop;
    result_t          out_data;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_INITIAL_LIMIT);
    assign cfg.load  = psel && penable && pwrite && reg_hit;
    assign cfg.value = pwdata[CFG_W-1:0];
    assign prdata    = reg_hit ? DATA_W'(initial_limit_reg) : '0;
    assign initial_limit_next = cfg.load ? cfg.value : initial_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            initial_limit_reg <= CFG_W'(RESET_LIMIT);
        else
            initial_limit_reg <= initial_limit_next;
    end

    pse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    pse_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_data   (out_data)
    );

    assign rsp.prime_value = out_data.prime_value;
    assign rsp.prime_flag  = out_data.prime_flag;
    assign rsp.status      = out_data.status;

endmodule

[hdl/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_sieve_query_engine_defines.svh"

module pse_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [pse_pkg::PV_W-1:0]    rsp_value,
    input logic                        rsp_flag,
    input logic [pse_pkg::ST_W-1:0]    rsp_status
);
    import pse_pkg::*;

    `PSE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_flag) && $stable(rsp_status), "stalled result changed")
    `PSE_ASSERT_NOW(a_status_code, clk, rst_n, rsp_valid, rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_BIG, "bad status code")
    `PSE_ASSERT_NOW(a_range_clean, clk, rst_n, rsp_valid && rsp_status == ST_RANGE, rsp_value == '0 && !rsp_flag, "range status with payload")
    `PSE_ASSERT_NOW(a_flag_clean, clk, rst_n, rsp_valid && rsp_flag, rsp_status == ST_OK && rsp_value == '0, "prime flag with value or error")

endmodule

bind prime_sieve_query_engine pse_checker u_pse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.prime_value),
    .rsp_flag   (rsp.prime_flag),
    .rsp_status (rsp.status)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prime_sieve_query_engine. Nth-prime and primality
// queries go through the valid/ready channels with random idling on both
// sides; a behavioural sieve computes every expected result. initial_limit
// is rewritten between phases, covering both clamps and a range of limits.
// ----------------------------------------------------------------------------
module tb;
    import pse_pkg::*;

    typedef struct {
        bit              kind;
        bit [IDX_W-1:0]  prime_index;
        bit [VAL_W-1:0]  test_value;
    } query_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pse_item_if   req_if ();
    pse_result_if rsp_if ();

    prime_sieve_query_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // behavioural sieve state
    bit          composite [0:BM_DEPTH-1];
    int unsigned primes [0:PRIME_SLOTS-1];
    int unsigned n_primes;
    int unsigned top_sieved;
    int unsigned seg_limit;
    int unsigned first_pass_cnt;

    query_t  pending_q [$];
    result_t answers_q [$];
    bit      calm = 1'b0;
    int      errors = 0;
    int      n_checked = 0;
    int      n_nth = 0;
    int      n_test = 0;
    int      n_limits = 0;

    function automatic void store_prime(int unsigned p);
        if (n_primes < PRIME_SLOTS)
        begin
            primes[n_primes] = p;
            n_primes++;
        end
    endfunction

    function automatic void strike(int unsigned s, int unsigned p, int unsigned hi);
        for (int unsigned m = s; m <= hi; m += 2 * p)
            composite[(m - 3) / 2] = 1'b1;
    endfunction

    function automatic void sieve_range(int unsigned lo, int unsigned hi);
        int unsigned lo_n;
        int unsigned hi_n;
        int unsigned known;
        int unsigned p;
        int unsigned s;
        lo_n  = 2 * lo + 3;
        hi_n  = 2 * hi + 3;
        known = n_primes;
        for (int unsigned k = 1; k < known; k++)
        begin
            p = primes[k];
            if (longint'(p) * p > hi_n)
                break;
            s = ((lo_n + p - 1) / p) * p;
            if (s[0] == 1'b0)
                s += p;
            if (s < p * p)
                s = p * p;
            strike(s, p, hi_n);
        end
        for (int unsigned i = lo; i <= hi; i++)
        begin
            if (!composite[i])
            begin
                p = 2 * i + 3;
                store_prime(p);
                if (longint'(p) * p <= hi_n)
                    strike(p * p, p, hi_n);
            end
        end
    endfunction

    function automatic void restart_sieve(bit [CFG_W-1:0] lim_reg);
        int unsigned lim;
        lim = lim_reg;
        if (lim < 3)
            lim = 3;
        if (lim > MAX_LIMIT)
            lim = MAX_LIMIT;
        foreach (composite[i])
            composite[i] = 1'b0;
        n_primes = 0;
        store_prime(2);
        seg_limit  = lim;
        top_sieved = (lim - 3) / 2;
        sieve_range(0, top_sieved);
        first_pass_cnt = n_primes;
    endfunction

    function automatic void grow_to(int unsigned want);
        int unsigned size;
        int unsigned hi;
        while (want >= n_primes && n_primes < PRIME_SLOTS && top_sieved < TOP_INDEX)
        begin
            size = seg_limit / 2;
            if (size < 1)
                size = 1;
            hi = top_sieved + size;
            if (hi > TOP_INDEX)
                hi = TOP_INDEX;
            sieve_range(top_sieved + 1, hi);
            top_sieved = hi;
            seg_limit = (seg_limit > MAX_LIMIT / 2) ? MAX_LIMIT : seg_limit * 2;
        end
    endfunction

    function automatic result_t answer_query(query_t q);
        result_t r;
        int unsigned top_p;
        int unsigned n;
        r = '0;
        r.status = ST_OK;
        n = q.test_value;
        if (q.kind == 1'b0)
        begin
            grow_to(q.prime_index);
            if (q.prime_index < n_primes)
                r.prime_value = primes[q.prime_index][PV_W-1:0];
            else
                r.status = ST_RANGE;
        end
        else if (n >= 2)
        begin
            top_p = primes[first_pass_cnt - 1];
            if (longint'(n) > longint'(top_p) * top_p)
                r.status = ST_BIG;
            else if (n <= top_p)
            begin
                if (n == 2)
                    r.prime_flag = 1'b1;
                else if (n[0])
                    r.prime_flag = !composite[(n - 3) / 2];
            end
            else
            begin
                r.prime_flag = 1'b1;
                for (int unsigned k = 0; k < first_pass_cnt; k++)
                    if (n % primes[k] == 0)
                    begin
                        r.prime_flag = 1'b0;
                        break;
                    end
            end
        end
        return r;
    endfunction

    // query driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.kind        <= 1'b0;
            req_if.prime_index <= '0;
            req_if.test_value  <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                query_t q;
                q.kind        = req_if.kind;
                q.prime_index = req_if.prime_index;
                q.test_value  = req_if.test_value;
                answers_q.insert(answers_q.size(), answer_query(q));
                if (q.kind)
                    n_test++;
                else
                    n_nth++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 21))
                begin
                    query_t q;
                    q = pending_q.pop_front();
                    req_if.kind        <= q.kind;
                    req_if.prime_index <= q.prime_index;
                    req_if.test_value  <= q.test_value;
                    req_if.valid       <= 1'b1;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 21);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (answers_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d flag=%0d status=%0d", $time,
                             rsp_if.prime_value, rsp_if.prime_flag, rsp_if.status);
                    errors++;
                end
                else
                begin
                    result_t e;
                    e = answers_q.pop_front();
                    n_checked++;
                    if (rsp_if.prime_value !== e.prime_value)
                    begin
                        $display("%0t: prime_value expected %0d actual %0d", $time,
                                 e.prime_value, rsp_if.prime_value);
                        errors++;
                    end
                    if (rsp_if.prime_flag !== e.prime_flag)
                    begin
                        $display("%0t: prime_flag expected %0d actual %0d", $time,
                                 e.prime_flag, rsp_if.prime_flag);
                        errors++;
                    end
                    if (rsp_if.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, rsp_if.status);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_query(bit kind, int unsigned idx, int unsigned val);
        query_t q;
        q.kind        = kind;
        q.prime_index = idx[IDX_W-1:0];
        q.test_value  = val;
        pending_q.insert(pending_q.size(), q);
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !req_if.valid);
        wait (answers_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(bit [CFG_W-1:0] v);
        drain();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INITIAL_LIMIT, 2'b00};
        pwdata  <= DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        restart_sieve(v);
        n_limits++;
    endtask

    task automatic random_queries(int count, int unsigned max_idx);
        int unsigned top_p;
        int unsigned sq;
        int unsigned pick;
        top_p = primes[first_pass_cnt - 1];
        sq = top_p * top_p;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
            begin
                drain();
                calm = 1'b1;
            end
            if (i == count / 2)
                calm = 1'b0;
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                if ($urandom_range(9) == 0)
                    push_query(1'b0, $urandom_range(8191), $urandom);
                else
                    push_query(1'b0, $urandom_range(max_idx), $urandom);
            end
            else if (pick < 70)
                push_query(1'b1, $urandom_range(IDX_W'(8191)), $urandom_range(top_p + 2));
            else if (pick < 78)
                push_query(1'b1, $urandom, $urandom_range(sq, top_p + 1));
            else if (pick < 85)
                push_query(1'b1, $urandom, sq + $urandom_range(2) - 1);
            else
                push_query(1'b1, $urandom, $urandom);
        end
    endtask

    initial
    begin
        restart_sieve(CFG_W'(RESET_LIMIT));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit 1024, largest first-pass prime 1021
        push_query(1'b0, 0, 0);
        push_query(1'b0, 1, 32'hFFFFFFFF);
        push_query(1'b0, 171, 0);
        push_query(1'b0, 172, 0);
        push_query(1'b0, 8191, 0);
        push_query(1'b0, 6541, 0);
        push_query(1'b0, 6542, 0);
        push_query(1'b1, 8191, 0);
        push_query(1'b1, 0, 1);
        push_query(1'b1, 0, 2);
        push_query(1'b1, 0, 3);
        push_query(1'b1, 0, 4);
        push_query(1'b1, 0, 9);
        push_query(1'b1, 0, 1021);
        push_query(1'b1, 0, 1022);
        push_query(1'b1, 0, 1023);
        push_query(1'b1, 0, 1031);
        push_query(1'b1, 0, 1042441);
        push_query(1'b1, 0, 1042442);
        push_query(1'b1, 0, 32'hFFFFFFFF);

        // clamp up to 65536: whole bitmap in the first pass
        write_limit(17'h1FFFF);
        push_query(1'b0, 6541, 0);
        push_query(1'b0, 8191, 0);
        push_query(1'b1, 0, 65521);
        push_query(1'b1, 0, 65535);
        push_query(1'b1, 0, 65538);
        push_query(1'b1, 0, 65541);
        push_query(1'b1, 0, 32'hFFFFFFFF);

        // clamp down to 3
        write_limit(17'd0);
        push_query(1'b0, 1, 0);
        push_query(1'b0, 2, 0);
        push_query(1'b1, 0, 9);
        push_query(1'b1, 0, 10);

        write_limit(17'd3);
        random_queries(450, 40);
        write_limit(17'd200);
        random_queries(450, 100);
        write_limit(17'd40);
        random_queries(450, 60);

        drain();
        repeat (200) @(posedge clk);
        if (answers_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, answers_q.size());
            errors += answers_q.size();
        end
        $display("Covered %0d nth-prime and %0d primality queries over %0d limit settings,",
                 n_nth, n_test, n_limits + 1);
        $display("%0d results compared, %0d mismatches.", n_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
